/* rtl/bmpd_pkg.sv */
// Shared types and constants for the 24-bit BMP stream decoder.
package bmpd_pkg;

  // Image bounds accepted by the header check.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Header layout: positions of the last byte of each checked field.
  localparam logic [15:0] POS_MAGIC    = 16'd1;
  localparam logic [15:0] POS_OFFSET   = 16'd13;
  localparam logic [15:0] POS_HDR_SIZE = 16'd17;
  localparam logic [15:0] POS_WIDTH    = 16'd21;
  localparam logic [15:0] POS_HEIGHT   = 16'd25;
  localparam logic [15:0] POS_PLANES   = 16'd27;
  localparam logic [15:0] POS_DEPTH    = 16'd29;
  localparam logic [15:0] POS_COMPRESS = 16'd33;
  localparam logic [15:0] POS_LAST     = 16'd53;
  localparam logic [15:0] HDR_BYTES    = 16'd54;

  // Expected header values.
  localparam logic [15:0] MAGIC_BM     = 16'h4D42;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [15:0] BITS_PER_PIX = 16'd24;
  localparam logic [15:0] ONE_PLANE    = 16'd1;
  localparam logic [31:0] MAX_OFFSET   = 32'd65535;

  // Verdict status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PLANES    = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_HDR_SIZE  = 3'd3;
  localparam logic [2:0] ST_DEPTH     = 3'd4;
  localparam logic [2:0] ST_COMPRESS  = 3'd5;
  localparam logic [2:0] ST_BOUNDS    = 3'd6;

  // Result kinds.
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // One input byte with its start-of-file flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  // One result item plus its valid flag.
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic        row_end;
    logic        frame_end;
  } result_t;

  // Handshake status of the input stage towards the core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

endpackage

/* rtl/bmpd_in_reg.sv */
// Input register stage of the BMP decoder.
module bmpd_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte
  input  logic              s_tuser,   // file_start
  input  logic              advance,
  output bmpd_pkg::in_stage_t stage
);

  logic               held_valid;
  bmpd_pkg::in_item_t held_item;

  // Space for a new transfer when empty or when the held byte moves on.
  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
    if (s_tready) begin
      held_item.data_byte  <= s_tdata;
      held_item.file_start <= s_tuser;
    end
  end

  assign stage.valid = held_valid;
  assign stage.item  = held_item;

endmodule

/* rtl/bmpd_core.sv */
// Parsing state and per-byte decode logic of the BMP decoder.
module bmpd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  bmpd_pkg::in_item_t item,
  output bmpd_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_HALT
  } phase_t;

  // Fault flag bit positions.
  localparam int F_MAGIC = 0;
  localparam int F_HSIZE = 1;
  localparam int F_DEPTH = 2;
  localparam int F_COMP  = 3;
  localparam int F_BOUND = 4;
  localparam int F_PLANE = 5;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] byte_index;
    logic [31:0] word_shift;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [15:0] data_offset;
    logic [7:0]  held_blue;
    logic [7:0]  held_green;
    logic [1:0]  byte_in_pixel;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic [1:0]  pad_left;
    logic [5:0]  faults;
  } state_t;

  state_t      st;
  state_t      cur;
  state_t      st_next;
  logic [31:0] ws;
  logic [2:0]  verdict;
  logic        last_col;
  logic        last_row;

  // Decode one byte against the current state, restarting on file_start.
  always_comb begin
    cur      = item.file_start ? '0 : st;
    st_next  = cur;
    res      = '0;
    ws       = {item.data_byte, cur.word_shift[31:8]};
    verdict  = bmpd_pkg::ST_OK;
    last_col = ({1'b0, cur.pixel_column} + 13'd1) >= cur.image_width;
    last_row = ({1'b0, cur.pixel_row} + 13'd1) >= cur.image_height;

    case (cur.phase)
      PH_HEADER: begin
        st_next.word_shift = ws;
        // Field checks on the byte that completes each field.
        if (cur.byte_index == bmpd_pkg::POS_MAGIC) begin
          if (ws[31:16] != bmpd_pkg::MAGIC_BM) st_next.faults[F_MAGIC] = 1'b1;
        end
        if (cur.byte_index == bmpd_pkg::POS_OFFSET) begin
          if (ws < 32'(bmpd_pkg::HDR_BYTES) || ws > bmpd_pkg::MAX_OFFSET) begin
            st_next.faults[F_BOUND] = 1'b1;
          end else begin
            st_next.data_offset = ws[15:0];
          end
        end
        if (cur.byte_index == bmpd_pkg::POS_HDR_SIZE) begin
          if (ws != bmpd_pkg::INFO_SIZE) st_next.faults[F_HSIZE] = 1'b1;
        end
        if (cur.byte_index == bmpd_pkg::POS_WIDTH) begin
          if (ws == 32'd0 || ws > 32'(bmpd_pkg::MAX_WIDTH)) begin
            st_next.faults[F_BOUND] = 1'b1;
          end else begin
            st_next.image_width = ws[12:0];
          end
        end
        if (cur.byte_index == bmpd_pkg::POS_HEIGHT) begin
          if (ws == 32'd0 || ws > 32'(bmpd_pkg::MAX_HEIGHT)) begin
            st_next.faults[F_BOUND] = 1'b1;
          end else begin
            st_next.image_height = ws[12:0];
          end
        end
        if (cur.byte_index == bmpd_pkg::POS_PLANES) begin
          if (ws[31:16] != bmpd_pkg::ONE_PLANE) st_next.faults[F_PLANE] = 1'b1;
        end
        if (cur.byte_index == bmpd_pkg::POS_DEPTH) begin
          if (ws[31:16] != bmpd_pkg::BITS_PER_PIX) st_next.faults[F_DEPTH] = 1'b1;
        end
        if (cur.byte_index == bmpd_pkg::POS_COMPRESS) begin
          if (ws != 32'd0) st_next.faults[F_COMP] = 1'b1;
        end

        // The first fault in priority order sets the verdict.
        if (cur.faults[F_MAGIC])      verdict = bmpd_pkg::ST_MAGIC;
        else if (cur.faults[F_HSIZE]) verdict = bmpd_pkg::ST_HDR_SIZE;
        else if (cur.faults[F_DEPTH]) verdict = bmpd_pkg::ST_DEPTH;
        else if (cur.faults[F_COMP])  verdict = bmpd_pkg::ST_COMPRESS;
        else if (cur.faults[F_BOUND]) verdict = bmpd_pkg::ST_BOUNDS;
        else if (cur.faults[F_PLANE]) verdict = bmpd_pkg::ST_PLANES;

        if (cur.byte_index == bmpd_pkg::POS_LAST) begin
          res.valid          = 1'b1;
          res.kind           = bmpd_pkg::KIND_VERDICT;
          res.status         = verdict;
          st_next.byte_index = bmpd_pkg::HDR_BYTES;
          if (verdict > bmpd_pkg::ST_PLANES) begin
            st_next.phase = PH_HALT;
          end else if (cur.data_offset > bmpd_pkg::HDR_BYTES) begin
            st_next.phase = PH_SKIP;
          end else begin
            st_next.phase = PH_PIXEL;
          end
        end else begin
          st_next.byte_index = cur.byte_index + 16'd1;
        end
      end

      PH_SKIP: begin
        // Count bytes up to the pixel data offset.
        st_next.byte_index = cur.byte_index + 16'd1;
        if (st_next.byte_index >= cur.data_offset) st_next.phase = PH_PIXEL;
      end

      PH_PIXEL: begin
        case (cur.byte_in_pixel)
          2'd0: begin
            st_next.held_blue     = item.data_byte;
            st_next.byte_in_pixel = 2'd1;
          end
          2'd1: begin
            st_next.held_green    = item.data_byte;
            st_next.byte_in_pixel = 2'd2;
          end
          default: begin
            // The red byte completes the pixel.
            res.valid             = 1'b1;
            res.kind              = bmpd_pkg::KIND_PIXEL;
            res.red               = item.data_byte;
            res.green             = cur.held_green;
            res.blue              = cur.held_blue;
            res.column            = cur.pixel_column;
            res.row_end           = last_col;
            res.frame_end         = last_col && last_row;
            st_next.byte_in_pixel = 2'd0;
            if (!last_col) begin
              st_next.pixel_column = cur.pixel_column + 12'd1;
            end else if (last_row) begin
              st_next.phase = PH_HALT;
            end else begin
              st_next.pixel_column = 12'd0;
              st_next.pixel_row    = cur.pixel_row + 12'd1;
              // Row padding (4 - 3w mod 4) mod 4 equals w mod 4.
              st_next.pad_left     = cur.image_width[1:0];
              if (cur.image_width[1:0] != 2'd0) st_next.phase = PH_PAD;
            end
          end
        endcase
      end

      PH_PAD: begin
        st_next.pad_left = cur.pad_left - 2'd1;
        if (st_next.pad_left == 2'd0) st_next.phase = PH_PIXEL;
      end

      default: begin
        // Halted: bytes are dropped until the next file start.
      end
    endcase
  end

  // State advances once for every byte handed on by the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

/* rtl/bmpd_out_reg.sv */
// Output result register of the BMP decoder.
module bmpd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bmpd_pkg::result_t res,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,  // status, red, green, blue, column, frame_end
  output logic              m_tuser,  // kind
  output logic              m_tlast,  // row_end
  output logic              free
);

  logic              held_valid;
  bmpd_pkg::result_t held;

  // The register can take a new result when empty or being drained.
  assign free = !held_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (step) begin
      held_valid <= res.valid;
    end else if (m_tready) begin
      held_valid <= 1'b0;
    end
    if (step) begin
      held <= res;
    end
  end

  assign m_tvalid = held_valid;
  assign m_tuser  = held.kind;
  assign m_tlast  = held.row_end;
  assign m_tdata  = {held.frame_end, held.column, held.blue, held.green,
                     held.red, held.status};

endmodule

/* rtl/bmp_24bit_stream_decoder_unit.sv */
// Top level of the 24-bit uncompressed BMP stream decoder.
//
// The decoder takes a BMP file one byte per transfer, with s_tuser high on the
// first byte of each file, and sustains one byte per clock while no result is
// held back by m_tready. It checks the 54-byte header and sends one verdict
// transfer (m_tuser high) on header byte 53; after an accepted verdict it skips
// to the pixel data offset and sends one pixel transfer for every blue, green,
// red byte triple, dropping row padding. m_tlast marks the last pixel of a row
// and bit 39 of m_tdata the last pixel of the image. A byte passes an input
// register, is decoded combinationally against the parsing state and lands in
// the output register, from which m_tvalid presents its result. The state
// updates once per byte and sets the rate; while a result waits on m_tready the
// input register takes at most one more byte and then holds s_tready low.
module bmp_24bit_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // file_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status, red, green, blue, column, frame_end
  output logic        m_tuser,   // kind
  output logic        m_tlast    // row_end
);

  bmpd_pkg::in_stage_t stage;
  bmpd_pkg::result_t   res;
  logic                out_free;
  logic                advance;

  // A held byte moves into the core when the result register can take it.
  assign advance = stage.valid && out_free;

  bmpd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .stage    (stage)
  );

  bmpd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (stage.item),
    .res  (res)
  );

  bmpd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .free     (out_free)
  );

endmodule
